// ----- rtl/lss_pkg.sv -----
// lss_pkg: shared types, codes and defaults for the lifo stack with statistics
// used by lss_cell, lss_stats and lifo_stack_with_stats; no dependencies
package lss_pkg;

  localparam int DEPTH_DEF     = 128;
  localparam int WORD_BITS_DEF = 32;

  // request kinds; the unused code behaves as a peek
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_ALT  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // request payload
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] push_value;
  } req_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic               is_empty;
    logic [7:0]         depth;
    logic [31:0]        push_count;
    logic [31:0]        pop_count;
    logic [7:0]         max_depth;
  } rsp_t;

  // shift command broadcast along the row of cells and to the counters
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ----- rtl/lss_cell.sv -----
// lss_cell: one storage slot of the shifting stack row
// depends on lss_pkg for the shift command struct
module lss_cell #(
  parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  lss_pkg::shift_t      shift,
  input  logic [WORD_BITS-1:0] from_above,
  input  logic [WORD_BITS-1:0] from_below,
  output logic [WORD_BITS-1:0] q
);
  import lss_pkg::*;

  // push moves words away from the top, pop moves them toward it
  always_ff @(posedge clk) begin
    if (shift.push) begin
      q <= from_above;
    end else if (shift.pop) begin
      q <= from_below;
    end
  end

endmodule

// ----- rtl/lss_stats.sv -----
// lss_stats: fill level, push and pop counters and high-water mark
// depends on lss_pkg for the shift command struct
module lss_stats #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF,
  localparam int FW   = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  lss_pkg::shift_t shift,
  output logic [FW-1:0]   fill,
  output logic [FW-1:0]   fill_next,
  output logic [FW-1:0]   deepest_next,
  output logic [31:0]     pushes_next,
  output logic [31:0]     pops_next
);
  import lss_pkg::*;

  logic [FW-1:0] deepest;
  logic [31:0]   pushes;
  logic [31:0]   pops;

  // values after the current transaction
  always_comb begin
    fill_next    = fill;
    pushes_next  = pushes;
    pops_next    = pops;
    if (shift.push) begin
      fill_next   = fill + FW'(1);
      pushes_next = pushes + 32'd1;
    end else if (shift.pop) begin
      fill_next = fill - FW'(1);
      pops_next = pops + 32'd1;
    end
    deepest_next = (fill_next > deepest) ? fill_next : deepest;
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      deepest <= '0;
      pushes  <= '0;
      pops    <= '0;
    end else begin
      fill    <= fill_next;
      deepest <= deepest_next;
      pushes  <= pushes_next;
      pops    <= pops_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill level above capacity");

  a_deepest_covers: assert property (@(posedge clk) disable iff (rst)
    deepest >= fill)
    else $error("high-water mark below fill level");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill) || fill == $past(fill) + FW'(1) ||
                     fill == $past(fill) - FW'(1)))
    else $error("fill level moved by more than one");

  a_push_counted: assert property (@(posedge clk) disable iff (rst)
    shift.push |=> pushes == $past(pushes) + 32'd1 && fill == $past(fill) + FW'(1))
    else $error("push not reflected in counters");

endmodule

// ----- rtl/lifo_stack_with_stats.sv -----
// lifo_stack_with_stats: bounded stack built as a shifting row of cells, with stats
// depends on lss_pkg, lss_cell and lss_stats
//
//   channel  direction  payload  transaction when
//   req      in         req_t    req_valid && req_ready
//   rsp      out        rsp_t    rsp_valid && rsp_ready
//
// one request per cycle while req_ready is high: every cell shifts in one step, top is always cell 0
// a taken request's result is registered on rsp, or into the skid entry while rsp is stalled
// a two-deep output buffer keeps req_ready high while one result waits
// rst is synchronous; it clears counters and handshake state, cells need no clear
module lifo_stack_with_stats #(
  parameter int DEPTH     = lss_pkg::DEPTH_DEF,
  parameter int WORD_BITS = lss_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lss_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lss_pkg::rsp_t rsp
);
  import lss_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic                 take;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] cell_q [DEPTH];
  shift_t               shift;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;
  logic [FW-1:0]        deepest_next;
  logic [31:0]          pushes_next;
  logic [31:0]          pops_next;
  logic                 is_full;
  logic                 is_empty_now;
  rsp_t                 result;
  logic                 skid_valid;
  rsp_t                 skid;

  assign take         = req_valid && req_ready;
  assign word_in      = WORD_BITS'($unsigned(req.push_value));
  assign is_full      = (fill == FW'(DEPTH));
  assign is_empty_now = (fill == '0);

  // decode the request into a shift command
  always_comb begin
    shift = '0;
    if (take) begin
      if (mode_t'(req.mode) == MODE_PUSH) begin
        shift.push = !is_full;
      end else if (mode_t'(req.mode) == MODE_POP) begin
        shift.pop = !is_empty_now;
      end
    end
  end

  // row of storage cells, cell 0 holds the top word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] above;
    logic [WORD_BITS-1:0] below;
    if (i == 0) begin : g_first
      assign above = word_in;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    lss_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  lss_stats #(.DEPTH(DEPTH)) u_stats (
    .clk          (clk),
    .rst          (rst),
    .shift        (shift),
    .fill         (fill),
    .fill_next    (fill_next),
    .deepest_next (deepest_next),
    .pushes_next  (pushes_next),
    .pops_next    (pops_next)
  );

  // assemble the result of the current request
  always_comb begin
    result.is_empty   = (fill_next == '0);
    result.depth      = 8'(fill_next);
    result.push_count = pushes_next;
    result.pop_count  = pops_next;
    result.max_depth  = 8'(deepest_next);
    if (mode_t'(req.mode) == MODE_PUSH) begin
      if (is_full) begin
        result.top_value = req.push_value;
        result.status    = ST_FULL;
      end else begin
        result.top_value = 32'(word_in);
        result.status    = ST_OK;
      end
    end else if (is_empty_now) begin
      result.top_value = '1;
      result.status    = ST_EMPTY;
    end else begin
      result.top_value = 32'(cell_q[0]);
      result.status    = ST_OK;
    end
  end

  // output register with one skid entry behind it
  assign req_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || rsp_ready) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= take;
        end else begin
          rsp_valid <= take;
        end
      end else if (take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      if (skid_valid) begin
        rsp <= skid;
        if (take) begin
          skid <= result;
        end
      end else if (take) begin
        rsp <= result;
      end
    end else if (take) begin
      skid <= result;
    end
  end

  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid entry held with output register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("accepted request produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule
